### design/fir_dec2_pkg.sv
`timescale 1ns / 1ps

package fir_dec2_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_COEF   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATE = 1'd1;

  // reset value of the tap count register
  localparam logic [6:0] NUM_TAPS_RST = 7'd64;

  // input transaction
  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [15:0] sample_value;
    logic        [5:0]  coef_index;
    logic signed [15:0] coef_value;
  } in_t;

  // output transaction
  typedef struct packed {
    logic signed [15:0] filtered_sample;
    logic               saturated;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic hist_push;
    logic hist_clr;
    logic coef_wr;
    logic mac_start;
    logic rd_en;
    logic res_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic decim;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } stat_t;

endpackage

### design/fir_dec2_ctrl.sv
`timescale 1ns / 1ps

module fir_dec2_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           req_type_i,
  output logic                 in_ready_o,
  input  fir_dec2_pkg::stat_t  stat_i,
  output fir_dec2_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_ISSUE,
    S_DRAIN
  } state_e;

  state_e state_q;
  logic   rdy_q;
  logic   phase_q;

  logic accept;
  logic is_sample;
  logic emit;
  logic load;

  // decode the accepted transaction
  assign accept    = in_valid_i && rdy_q;
  assign is_sample = (req_type_i == fir_dec2_pkg::REQ_SAMPLE);
  assign emit      = !stat_i.decim || !phase_q;
  assign load      = (state_q == S_DRAIN) && !stat_i.pipe_busy && stat_i.out_free;

  // commands to the datapath
  always_comb begin
    cmd_o           = '0;
    cmd_o.hist_push = accept && is_sample;
    cmd_o.coef_wr   = accept && (req_type_i == fir_dec2_pkg::REQ_COEF);
    cmd_o.hist_clr  = accept && (req_type_i == fir_dec2_pkg::REQ_CLEAR);
    cmd_o.mac_start = (state_q == S_SETUP);
    cmd_o.rd_en     = (state_q == S_ISSUE);
    cmd_o.res_load  = load;
  end

  assign in_ready_o = rdy_q;

  // state, ready flag and decimation phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
      phase_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (req_type_i == fir_dec2_pkg::REQ_CLEAR) begin
              phase_q <= 1'b0;
            end else if (is_sample) begin
              if (stat_i.decim) begin
                phase_q <= ~phase_q;
              end
              if (emit) begin
                state_q <= S_SETUP;
                rdy_q   <= 1'b0;
              end
            end
          end
        end
        S_SETUP: begin
          state_q <= S_ISSUE;
        end
        S_ISSUE: begin
          if (stat_i.last_issue) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (load) begin
            state_q <= S_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

endmodule

### design/fir_dec2_dp.sv
`timescale 1ns / 1ps

module fir_dec2_dp #(
  parameter int unsigned MAX_TAPS = 64
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  fir_dec2_pkg::in_t                          in_data_i,
  input  logic                                       cfg_we_i,
  input  logic [fir_dec2_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [fir_dec2_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  fir_dec2_pkg::cmd_t                         cmd_i,
  output fir_dec2_pkg::stat_t                        stat_o,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output fir_dec2_pkg::out_t                         out_data_o
);

  localparam int unsigned AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned ACCW = 32 + AW;
  localparam logic [8:0]    MAXT9 = 9'(MAX_TAPS);
  localparam logic [AW:0]   MAXTA = (AW + 1)'(MAX_TAPS);
  localparam logic [AW-1:0] LAST  = AW'(MAX_TAPS - 1);

  // configuration registers
  logic [6:0] num_taps_q;
  logic       decim_q;

  // storage
  logic signed [15:0] coef_mem [MAX_TAPS];
  logic signed [15:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0] hv_q;
  logic [AW-1:0]       wp_q;

  // mac pipeline
  logic [AW-1:0]           a_q;
  logic [AW-1:0]           ca_q;
  logic [AW-1:0]           cnt_q;
  logic                    rdv_q;
  logic                    pv_q;
  logic signed [15:0]      cdat_q;
  logic signed [15:0]      hdat_q;
  logic signed [31:0]      prod_q;
  logic signed [ACCW-1:0]  acc_q;

  // output register
  logic                ovalid_q;
  fir_dec2_pkg::out_t  out_q;

  logic [8:0]    nt9;
  logic [8:0]    ntc;
  logic [AW-1:0] taps_m1;
  logic [AW-1:0] wp_nxt;
  logic [AW-1:0] a_nxt;
  logic [AW:0]   start_raw;
  logic [AW-1:0] start_addr;
  logic          coef_ok;
  logic [AW-1:0] coef_addr;
  logic          fits;
  logic signed [15:0] y;

  // tap count limited to 1..MAX_TAPS
  assign nt9     = {2'b00, num_taps_q};
  assign ntc     = (nt9 == 9'd0) ? 9'd1 : ((nt9 > MAXT9) ? MAXT9 : nt9);
  assign taps_m1 = AW'(ntc - 9'd1);

  // circular pointers
  assign wp_nxt = (wp_q == LAST) ? '0 : wp_q + 1'b1;
  assign a_nxt  = (a_q == LAST) ? '0 : a_q + 1'b1;

  // oldest tap in use sits taps_m1 entries behind the newest
  assign start_raw  = {1'b0, wp_q} + MAXTA - {1'b0, taps_m1};
  assign start_addr = (start_raw >= MAXTA) ? AW'(start_raw - MAXTA) : AW'(start_raw);

  // coefficient slot check
  assign coef_ok   = ({3'b000, in_data_i.coef_index} < MAXT9);
  assign coef_addr = AW'(in_data_i.coef_index);

  // shift by 15 and clip to 16 bits
  assign fits = (acc_q[ACCW-1:30] == '0) || (acc_q[ACCW-1:30] == '1);
  assign y    = fits ? acc_q[30:15] : (acc_q[ACCW-1] ? 16'sh8000 : 16'sh7fff);

  // status to the controller
  assign stat_o.decim      = decim_q;
  assign stat_o.last_issue = (cnt_q == '0);
  assign stat_o.pipe_busy  = rdv_q || pv_q;
  assign stat_o.out_free   = !ovalid_q || out_ready_i;

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_taps_q <= fir_dec2_pkg::NUM_TAPS_RST;
      decim_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fir_dec2_pkg::CFG_NUM_TAPS: num_taps_q <= cfg_data_i[6:0];
        fir_dec2_pkg::CFG_DECIMATE: decim_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // coefficient memory, read in tap order from slot 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr && coef_ok) begin
      coef_mem[coef_addr] <= in_data_i.coef_value;
    end
    if (cmd_i.rd_en) begin
      cdat_q <= coef_mem[ca_q];
    end
  end

  // sample history memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_push) begin
      hist_mem[wp_nxt] <= in_data_i.sample_value;
    end
    if (cmd_i.rd_en) begin
      hdat_q <= hv_q[a_q] ? hist_mem[a_q] : 16'sd0;
    end
  end

  // history valid bits and write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= '0;
      wp_q <= '0;
    end else if (cmd_i.hist_clr) begin
      hv_q <= '0;
    end else if (cmd_i.hist_push) begin
      hv_q[wp_nxt] <= 1'b1;
      wp_q         <= wp_nxt;
    end
  end

  // read addresses and tap counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= '0;
      ca_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.mac_start) begin
      a_q   <= start_addr;
      ca_q  <= '0;
      cnt_q <= taps_m1;
    end else if (cmd_i.rd_en) begin
      a_q   <= a_nxt;
      ca_q  <= ca_q + 1'b1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      pv_q  <= 1'b0;
    end else begin
      rdv_q <= cmd_i.rd_en;
      pv_q  <= rdv_q;
    end
  end

  // multiply then accumulate
  always_ff @(posedge clk_i) begin
    if (rdv_q) begin
      prod_q <= cdat_q * hdat_q;
    end
    if (cmd_i.mac_start) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACCW'(prod_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q.filtered_sample <= y;
      out_q.saturated       <= !fits;
    end
  end

endmodule

### design/fir_filter_decimate_by_two.sv
`timescale 1ns / 1ps

// FIR filter over a Q1.15 sample stream with optional decimate-by-two. Each input
// transaction is a sample, a coefficient write or a history clear; coefficient writes
// and clears leave the input ready and give no result. A sample that yields a result
// runs through one setup step, then one tap per cycle through a single shared 16x16
// multiply-accumulate fed from the coefficient and history memories, then a drain of
// the read, multiply and accumulate stages before the output register is loaded; the
// load waits, and the input with it, while an earlier result still sits untaken in the
// output register.
// In decimate mode every second sample after reset or clear starts no run and gives
// no result. The output register lets the next transaction be accepted while a result
// waits to be taken. Every coefficient slot in use must be written before the first
// sample that reads it. Registers: index 0 is num_taps, index 1 is decimate_by_two;
// write them only while the filter is idle.
module fir_filter_decimate_by_two #(
  parameter int unsigned MAX_TAPS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fir_dec2_pkg::in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fir_dec2_pkg::out_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [fir_dec2_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fir_dec2_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fir_dec2_pkg::cmd_t  cmd;
  fir_dec2_pkg::stat_t stat;

  // sequencing
  fir_dec2_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // memories, mac and output register
  fir_dec2_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/fir_dec2_checker.sv
`timescale 1ns / 1ps

module fir_dec2_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input fir_dec2_pkg::in_t                   in_data_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input fir_dec2_pkg::out_t                  out_data_o,
  input logic                                cfg_we_i,
  input logic [fir_dec2_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [fir_dec2_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic decim_q;
  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // track the decimate register from the write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q <= 1'b0;
    end else if (cfg_we_i && (cfg_idx_i == fir_dec2_pkg::CFG_DECIMATE)) begin
      decim_q <= cfg_data_i[0];
    end
  end

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // coefficient writes and clears never block the input
  a_short_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.req_type != fir_dec2_pkg::REQ_SAMPLE) |=> in_ready_o)
    else $error("input blocked after a non-sample transaction");

  // a sample outside decimate mode starts a filter run
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.req_type == fir_dec2_pkg::REQ_SAMPLE) && !decim_q |=> !in_ready_o)
    else $error("sample accepted without starting a run");

  // a new result only ends a run
  a_result_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while idle");

endmodule

bind fir_filter_decimate_by_two fir_dec2_checker u_fir_dec2_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fir_dec2_pkg::*;

  localparam int unsigned MAX_TAPS = 64;
  localparam int unsigned SETTLE_CYCLES = MAX_TAPS + 16;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned GAP_MAX = 40;
  // request code the filter ignores
  localparam logic [1:0] REQ_NONE = 2'd3;

  // one row of the directed stimulus
  typedef struct {
    logic [6:0] taps;
    bit         dec;
    in_t        item;
    bit         given;
    out_t       val;
  } probe_row_t;

  // one random phase: settings, idling and pressure
  typedef struct packed {
    logic [6:0]  taps;
    bit          dec;
    int unsigned send_pct;
    int unsigned recv_pct;
    int unsigned items;
    bit          long_hold;
    bit          mid_pause;
  } phase_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  // typed expectation travelling with the input transaction
  bit          drive_given;
  out_t        drive_val;

  // predictor state
  logic signed [15:0] hist_mem [MAX_TAPS];
  logic signed [15:0] coef_mem [MAX_TAPS];
  bit                 dec_phase;
  logic [6:0]         model_taps;
  bit                 model_decim;

  out_t        filt_expected [$];
  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_armed;

  probe_row_t  probes [$];
  phase_t      plan [9] = '{
    '{7'd64,  1'b0, 0,  0,  150, 1'b1, 1'b0},
    '{7'd0,   1'b1, 81, 0,  100, 1'b0, 1'b0},
    '{7'd127, 1'b0, 0,  81, 150, 1'b0, 1'b0},
    '{7'd5,   1'b1, 18, 18, 150, 1'b0, 1'b0},
    '{7'd65,  1'b1, 0,  0,  100, 1'b0, 1'b1},
    '{7'd33,  1'b0, 81, 0,  150, 1'b0, 1'b0},
    '{7'd2,   1'b0, 0,  81, 100, 1'b0, 1'b0},
    '{7'd17,  1'b1, 18, 18, 150, 1'b0, 1'b0},
    '{7'd1,   1'b0, 0,  0,  50,  1'b0, 1'b0}
  };

  fir_filter_decimate_by_two #(
    .MAX_TAPS(MAX_TAPS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // predicted filter: updates state, returns 1 when a result is due
  function automatic bit fir_step_predict(input in_t item, output out_t res);
    longint acc;
    longint y;
    int     n;
    int     k;
    bit     emit;
    res = '0;
    acc = 0;
    case (item.req_type)
      REQ_COEF: begin
        coef_mem[item.coef_index] = item.coef_value;
        return 1'b0;
      end
      REQ_CLEAR: begin
        for (k = 0; k < MAX_TAPS; k++) hist_mem[k] = '0;
        dec_phase = 1'b0;
        return 1'b0;
      end
      REQ_SAMPLE: ;
      default: return 1'b0;
    endcase
    for (k = MAX_TAPS - 1; k > 0; k--) hist_mem[k] = hist_mem[k-1];
    hist_mem[0] = item.sample_value;
    emit = 1'b1;
    if (model_decim) begin
      emit = (dec_phase == 1'b0);
      dec_phase = ~dec_phase;
    end
    if (!emit) return 1'b0;
    n = int'(model_taps);
    if (n < 1) n = 1;
    if (n > MAX_TAPS) n = MAX_TAPS;
    // tap 0 pairs with the oldest of the n newest samples
    for (k = 0; k < n; k++) acc += longint'(coef_mem[k]) * longint'(hist_mem[n-1-k]);
    y = acc >>> 15;
    if (y > 32767) begin
      y = 32767;
      res.saturated = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      res.saturated = 1'b1;
    end
    res.filtered_sample = y[15:0];
    return 1'b1;
  endfunction

  function automatic in_t make_item(logic [1:0] req, int s, int idx, int c);
    in_t it;
    it.req_type = req;
    it.sample_value = 16'(s);
    it.coef_index = 6'(idx);
    it.coef_value = 16'(c);
    return it;
  endfunction

  function automatic out_t make_out(int v, bit sat);
    out_t o;
    o.filtered_sample = 16'(v);
    o.saturated = sat;
    return o;
  endfunction

  function automatic probe_row_t row(logic [6:0] taps, bit dec, logic [1:0] req, int s,
                                     int idx, int c, bit given, int v, bit sat);
    probe_row_t r;
    r.taps = taps;
    r.dec = dec;
    r.item = make_item(req, s, idx, c);
    r.given = given;
    r.val = make_out(v, sat);
    return r;
  endfunction

  // q1.15 value biased toward the extremes and small magnitudes
  function automatic logic [15:0] rand_q15();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'(int'($urandom_range(0, 600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t random_item();
    in_t         it;
    int unsigned pick;
    it.sample_value = rand_q15();
    it.coef_value = rand_q15();
    it.coef_index = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 75) it.req_type = REQ_SAMPLE;
    else if (pick < 90) it.req_type = REQ_COEF;
    else if (pick < 96) it.req_type = REQ_CLEAR;
    else it.req_type = REQ_NONE;
    return it;
  endfunction

  // wait until every expected result has been taken
  task automatic wait_drained();
    do @(posedge clk_i); while (filt_expected.size() != 0);
  endtask

  // both registers, written back to back while the filter is idle
  task automatic set_cfg(input logic [6:0] taps, input bit dec);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_NUM_TAPS;
    cfg_data <= taps;
    @(posedge clk_i);
    cfg_idx <= CFG_DECIMATE;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, dec};
    @(posedge clk_i);
    cfg_we <= 1'b0;
    model_taps = taps;
    model_decim = dec;
  endtask

  // drain, let a skipped sample or write finish, then reconfigure
  task automatic reconfigure(input logic [6:0] taps, input bit dec);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    set_cfg(taps, dec);
  endtask

  // offer one input transaction, with an optional idle gap in front
  task automatic send_item(input in_t item, input bit given, input out_t val,
                           input bit drain_first);
    int unsigned gap;
    gap = 0;
    while (gap < GAP_MAX && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0 || drain_first) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain_first) wait_drained();
    end
    in_valid <= 1'b1;
    in_data <= item;
    drive_given <= given;
    drive_val <= val;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // result side: random stalls and one long hold when armed
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // scoreboard, prediction on accepted inputs, and watchdog
  always @(posedge clk_i) begin : scoreboard
    out_t want;
    out_t pred;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (filt_expected.size() == 0) begin
          $display("%0t: unexpected result %0d sat %0b", $time,
                   $signed(out_data.filtered_sample), out_data.saturated);
          error_count++;
        end else begin
          want = filt_expected.pop_front();
          if (want.filtered_sample !== out_data.filtered_sample) begin
            $display("%0t: filtered_sample expected %0d actual %0d", $time,
                     $signed(want.filtered_sample), $signed(out_data.filtered_sample));
            error_count++;
          end
          if (want.saturated !== out_data.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time,
                     want.saturated, out_data.saturated);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (fir_step_predict(in_data, pred)) filt_expected.push_back(drive_given ? drive_val : pred);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("testbench: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int         k;
    int         j;
    probe_row_t r;
    phase_t     p;
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    drive_given <= 1'b0;
    drive_val <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    error_count = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_armed = 1'b0;
    for (k = 0; k < MAX_TAPS; k++) begin
      hist_mem[k] = '0;
      coef_mem[k] = '0;
    end
    dec_phase = 1'b0;
    model_taps = NUM_TAPS_RST;
    model_decim = 1'b0;

    // directed rows: extremes, rounding, ignored code, clear, tap limits, decimation
    probes.push_back(row(7'd1, 0, REQ_COEF,   0,      0,  32767,  0, 0, 0));
    probes.push_back(row(7'd1, 0, REQ_SAMPLE, 32767,  0,  0,      1, 32766, 0));
    probes.push_back(row(7'd1, 0, REQ_SAMPLE, -32768, 0,  0,      1, -32767, 0));
    probes.push_back(row(7'd1, 0, REQ_COEF,   0,      0,  -32768, 0, 0, 0));
    probes.push_back(row(7'd1, 0, REQ_SAMPLE, -32768, 0,  0,      1, 32767, 1));
    probes.push_back(row(7'd1, 0, REQ_SAMPLE, 32767,  0,  0,      1, -32767, 0));
    probes.push_back(row(7'd1, 0, REQ_SAMPLE, 0,      0,  0,      1, 0, 0));
    probes.push_back(row(7'd1, 0, REQ_SAMPLE, -1,     0,  0,      1, 1, 0));
    probes.push_back(row(7'd1, 0, REQ_COEF,   0,      0,  1,      0, 0, 0));
    probes.push_back(row(7'd1, 0, REQ_SAMPLE, -1,     0,  0,      1, -1, 0));
    probes.push_back(row(7'd1, 0, REQ_NONE,   -1,     63, -1,     0, 0, 0));
    probes.push_back(row(7'd1, 0, REQ_COEF,   0,      63, 32767,  0, 0, 0));
    probes.push_back(row(7'd0, 0, REQ_SAMPLE, 16384,  0,  0,      1, 0, 0));
    probes.push_back(row(7'd0, 0, REQ_COEF,   0,      1,  -32768, 0, 0, 0));
    probes.push_back(row(7'd2, 0, REQ_COEF,   0,      0,  -32768, 0, 0, 0));
    probes.push_back(row(7'd2, 0, REQ_SAMPLE, 32767,  0,  0,      1, -32768, 1));
    probes.push_back(row(7'd2, 0, REQ_CLEAR,  0,      0,  0,      0, 0, 0));
    probes.push_back(row(7'd2, 0, REQ_SAMPLE, 5,      0,  0,      1, -5, 0));
    probes.push_back(row(7'd2, 1, REQ_SAMPLE, 100,    0,  0,      0, 0, 0));
    probes.push_back(row(7'd2, 1, REQ_SAMPLE, 200,    0,  0,      0, 0, 0));
    probes.push_back(row(7'd2, 1, REQ_SAMPLE, 300,    0,  0,      0, 0, 0));
    probes.push_back(row(7'd2, 1, REQ_CLEAR,  0,      0,  0,      0, 0, 0));
    probes.push_back(row(7'd2, 1, REQ_SAMPLE, -7,     0,  0,      0, 0, 0));
    probes.push_back(row(7'd2, 1, REQ_COEF,   0,      2,  4660,   0, 0, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_cfg(probes[0].taps, probes[0].dec);

    // directed walk, reconfiguring whenever a row asks for other settings
    foreach (probes[k]) begin
      r = probes[k];
      if (r.taps != model_taps || r.dec != model_decim) reconfigure(r.taps, r.dec);
      send_item(r.item, r.given, r.val, 1'b0);
    end

    // load every coefficient slot before wider filters read them
    for (k = 0; k < MAX_TAPS; k++) begin
      send_item(make_item(REQ_COEF, int'(rand_q15()), k, int'(rand_q15())), 1'b0, '0, 1'b0);
    end

    // random phases over several settings and idling patterns
    foreach (plan[k]) begin
      p = plan[k];
      reconfigure(p.taps, p.dec);
      idle_pct = p.send_pct;
      stall_pct = p.recv_pct;
      hold_armed = p.long_hold;
      for (j = 0; j < int'(p.items); j++) begin
        send_item(random_item(), 1'b0, '0, p.mid_pause && j == int'(p.items) / 2);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && filt_expected.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
